// ===== hdl/ialu_pkg.sv =====
`default_nettype none
package ialu_pkg;

  localparam int DW = 64;

  localparam logic [3:0] OP_ADD  = 4'd0;
  localparam logic [3:0] OP_SUB  = 4'd1;
  localparam logic [3:0] OP_MUL  = 4'd2;
  localparam logic [3:0] OP_DIV  = 4'd3;
  localparam logic [3:0] OP_MOD  = 4'd4;
  localparam logic [3:0] OP_AND  = 4'd5;
  localparam logic [3:0] OP_OR   = 4'd6;
  localparam logic [3:0] OP_XOR  = 4'd7;
  localparam logic [3:0] OP_SHL  = 4'd8;
  localparam logic [3:0] OP_SHR  = 4'd9;
  localparam logic [3:0] OP_ROL  = 4'd10;
  localparam logic [3:0] OP_ROR  = 4'd11;
  localparam logic [3:0] OP_NEG  = 4'd12;
  localparam logic [3:0] OP_NOT  = 4'd13;
  localparam logic [3:0] OP_ASR  = 4'd14;
  localparam logic [3:0] OP_BSWP = 4'd15;

  typedef struct packed {
    logic [3:0]    func;
    logic [DW-1:0] res;
    logic          neg_r;
    logic          neg_q;
    logic          bz;
  } side_t;

endpackage
`default_nettype wire

// ===== hdl/ialu_div.sv =====
`default_nettype none
module ialu_div
  import ialu_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic          in_valid,
  input  wire logic [DW-1:0] dividend,
  input  wire logic [DW-1:0] divisor,
  input  wire side_t         in_side,
  output logic               out_valid,
  output logic [DW-1:0]      quo,
  output logic [DW-1:0]      rem,
  output side_t              out_side
);

  logic          v  [0:DW];
  logic [DW-1:0] rm [0:DW];
  logic [DW-1:0] qt [0:DW];
  logic [DW-1:0] dv [0:DW];
  side_t         sd [0:DW];

  assign v[0]  = in_valid;
  assign rm[0] = '0;
  assign qt[0] = dividend;
  assign dv[0] = divisor;
  assign sd[0] = in_side;

  for (genvar i = 0; i < DW; i++) begin : g_step
    logic [DW:0] t;
    logic [DW:0] diff;
    logic        ge;
    assign t    = {rm[i], qt[i][DW-1]};
    assign diff = t - {1'b0, dv[i]};
    assign ge   = t >= {1'b0, dv[i]};

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i+1] <= 1'b0;
      end else if (en) begin
        v[i+1] <= v[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rm[i+1] <= ge ? diff[DW-1:0] : t[DW-1:0];
        qt[i+1] <= {qt[i][DW-2:0], ge};
        dv[i+1] <= dv[i];
        sd[i+1] <= sd[i];
      end
    end
  end

  assign out_valid = v[DW];
  assign quo       = qt[DW];
  assign rem       = rm[DW];
  assign out_side  = sd[DW];

endmodule
`default_nettype wire

// ===== hdl/integer_alu_with_flags.sv =====
// 64-bit integer ALU with zero and negative flags.
// Input channel s_*: s_tdata carries operand_a (bits 63:0) and operand_b
// (bits 127:64); s_tuser carries func (bits 3:0) and signed_mode (bit 4).
// Output channel m_*: m_tdata carries the result; m_tuser carries
// zero_flag (bit 0) and negative_flag (bit 1).
// Every word gives exactly one result word, in order.
// Every opcode takes the same path: one stage for operand prep,
// shifts, logic and the 32x32 partial products, one stage to sum the
// product, 64 one-bit restoring divide stages, and one stage for the
// sign fixup and flags.
// Throughput is one word per cycle for all opcodes unless the receiver stalls.
// Reset clears all stage valid bits; the pipe then is empty and ready.
// When the receiver stalls with a result waiting, the whole pipe holds
// and s_tready drops; nothing is lost or repeated.
`default_nettype none
module integer_alu_with_flags
  import ialu_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            s_tvalid,
  output logic                 s_tready,
  input  wire logic [2*DW-1:0] s_tdata,   // operand_a, operand_b
  input  wire logic [4:0]      s_tuser,   // func, signed_mode
  output logic                 m_tvalid,
  input  wire logic            m_tready,
  output logic [DW-1:0]        m_tdata,   // result
  output logic [1:0]           m_tuser    // zero_flag, negative_flag
);

  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  logic [3:0]    func;
  logic          sgn;
  logic [DW-1:0] a;
  logic [DW-1:0] b;
  logic [5:0]    sh;
  assign a    = s_tdata[DW-1:0];
  assign b    = s_tdata[2*DW-1:DW];
  assign func = s_tuser[3:0];
  assign sgn  = s_tuser[4];
  assign sh   = b[5:0];

  logic [DW-1:0]   simple;
  logic [2*DW-1:0] rot_l;
  logic [2*DW-1:0] rot_r;
  logic [DW-1:0]   asr;
  logic [DW-1:0]   bsw;
  logic            na;
  logic            nb;

  assign rot_l = {a, a} << sh;
  assign rot_r = {a, a} >> sh;
  assign asr   = $unsigned($signed(a) >>> sh);
  assign na    = sgn && a[DW-1];
  assign nb    = sgn && b[DW-1];

  always_comb begin
    for (int i = 0; i < DW / 8; i++) begin
      bsw[8*i +: 8] = a[DW-8-8*i +: 8];
    end
  end

  always_comb begin
    case (func)
      OP_ADD:  simple = a + b;
      OP_SUB:  simple = a - b;
      OP_AND:  simple = a & b;
      OP_OR:   simple = a | b;
      OP_XOR:  simple = a ^ b;
      OP_SHL:  simple = a << sh;
      OP_SHR:  simple = sgn ? asr : (a >> sh);
      OP_ROL:  simple = rot_l[2*DW-1:DW];
      OP_ROR:  simple = rot_r[DW-1:0];
      OP_NEG:  simple = -a;
      OP_NOT:  simple = ~a;
      OP_ASR:  simple = asr;
      OP_BSWP: simple = bsw;
      default: simple = '0;
    endcase
  end

  logic          v1;
  side_t         sd1;
  logic [DW-1:0] p0;
  logic [31:0]   p1;
  logic [31:0]   p2;
  logic [DW-1:0] ua1;
  logic [DW-1:0] ub1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd1.func  <= func;
      sd1.res   <= simple;
      sd1.neg_r <= na;
      sd1.neg_q <= na ^ nb;
      sd1.bz    <= b == '0;
      p0        <= DW'(a[31:0]) * DW'(b[31:0]);
      p1        <= 32'(a[31:0] * b[63:32]);
      p2        <= 32'(a[63:32] * b[31:0]);
      ua1       <= na ? -a : a;
      ub1       <= nb ? -b : b;
    end
  end

  logic          v2;
  side_t         sd2;
  logic [DW-1:0] ua2;
  logic [DW-1:0] ub2;
  logic [31:0]   p_mid;
  assign p_mid = p1 + p2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd2.func  <= sd1.func;
      sd2.res   <= (sd1.func == OP_MUL) ? p0 + {p_mid, 32'd0} : sd1.res;
      sd2.neg_r <= sd1.neg_r;
      sd2.neg_q <= sd1.neg_q;
      sd2.bz    <= sd1.bz;
      ua2       <= ua1;
      ub2       <= ub1;
    end
  end

  logic          vd;
  logic [DW-1:0] quo;
  logic [DW-1:0] rem;
  side_t         sdd;

  ialu_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v2),
    .dividend  (ua2),
    .divisor   (ub2),
    .in_side   (sd2),
    .out_valid (vd),
    .quo       (quo),
    .rem       (rem),
    .out_side  (sdd)
  );

  logic [DW-1:0] fin;
  always_comb begin
    case (sdd.func)
      OP_DIV:  fin = sdd.bz ? '1 : (sdd.neg_q ? -quo : quo);
      OP_MOD:  fin = sdd.neg_r ? -rem : rem;
      default: fin = sdd.res;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= vd;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata    <= fin;
      m_tuser[0] <= fin == '0;
      m_tuser[1] <= fin[DW-1];
    end
  end

  a_v2_follows: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) && $past(en) |-> v2 == $past(v1))
    else $error("stage 2 valid lost or invented");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) && $past(!en) |-> $stable(v1) && $stable(v2) && $stable(m_tvalid))
    else $error("pipe moved during stall");

  a_flags: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser[0] == (m_tdata == '0)) && (m_tuser[1] == m_tdata[DW-1]))
    else $error("flags disagree with result");

endmodule
`default_nettype wire
